// ===== rtl/pngunf_pkg.sv =====
`default_nettype none

package pngunf_pkg;

  // default sizing limits
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;
  localparam int MAX_BPP_DEF    = 4;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_BPP_W  = 3;
  localparam int MIN_BPP    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH     = 2'd0,
    CFG_IMAGE_HEIGHT    = 2'd1,
    CFG_BYTES_PER_PIXEL = 2'd2
  } cfg_reg_t;

  // PNG filter types
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

endpackage

`default_nettype wire

// ===== rtl/pngunf_ram.sv =====
`default_nettype none

module pngunf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/png_scanline_unfilter.sv =====
`default_nettype none
// PNG scanline reconstruction (None/Sub/Up/Average/Paeth), one byte per clock.
//
// Input channel (in_valid/in_stall): the inflated image stream. The first
// byte of each row is its filter type; width * bytes-per-pixel filtered bytes
// follow. in_frame_start on a byte restarts the image; that byte is the
// filter type of row 0. A filter type above 4 flags the row (out_bad_filter)
// and the row is passed through as None. Filter bytes give no output.
// Output channel (out_valid/out_stall): one reconstructed byte per data byte,
// with end-of-row and end-of-image marks.
// Config (cfg_valid/cfg_ready, always ready): 0 width, 1 height, 2 bytes per
// pixel. Write only while no transfer is in flight.
// Throughput: one byte per cycle while the output is not stalled. Each data
// byte is read out of the line buffer at its input transfer, held in the
// reconstruct stage and then loaded into the output register. Rate is set
// by the single read/write port pair of the prior-row line buffer.
// Reset: row/column state cleared, registers back to width 1, height 1,
// 3 bytes per pixel; the line buffer is not cleared (row 0 ignores its data).
// Receiver stall: the output register holds, one more byte waits in the
// reconstruct stage, then in_stall rises.

module png_scanline_unfilter #(
  parameter int MAX_WIDTH           = pngunf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT          = pngunf_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_BYTES_PER_PIXEL = pngunf_pkg::MAX_BPP_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input stream
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [7:0]                        in_byte,
  input  wire logic                              in_frame_start,
  // result stream
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [7:0]                             out_byte,
  output logic                                   out_bad_filter,
  output logic                                   out_end_of_row,
  output logic                                   out_end_of_image,
  // register writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [pngunf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pngunf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int LINE_DEPTH = MAX_WIDTH * MAX_BYTES_PER_PIXEL;
  localparam int COL_W  = $clog2(LINE_DEPTH);
  localparam int LEN_W  = $clog2(LINE_DEPTH + 1);
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int BPP_W  = $clog2(MAX_BYTES_PER_PIXEL + 1);
  localparam int KW     = $clog2(MAX_BYTES_PER_PIXEL);
  localparam int CD_W   = pngunf_pkg::CFG_DATA_W;
  localparam int WCMP_W = (WID_W > CD_W) ? WID_W : CD_W;
  localparam int HCMP_W = (HGT_W > CD_W) ? HGT_W : CD_W;
  localparam int BCMP_W = (BPP_W > pngunf_pkg::CFG_BPP_W) ? BPP_W : pngunf_pkg::CFG_BPP_W;
  localparam int MINB   = pngunf_pkg::MIN_BPP;

  // ---------------------------------------------------------------- config
  logic [CD_W-1:0]                    cfg_width_r;
  logic [CD_W-1:0]                    cfg_height_r;
  logic [pngunf_pkg::CFG_BPP_W-1:0]   cfg_bpp_r;

  assign cfg_ready = 1'b1;

  // clamped register values
  logic [WCMP_W-1:0] w_ext, w_clamp;
  logic [HCMP_W-1:0] h_ext, h_clamp;
  logic [BCMP_W-1:0] b_ext, b_clamp;
  logic [WID_W-1:0]  width;
  logic [HGT_W-1:0]  height;
  logic [BPP_W-1:0]  bpp;
  logic [LEN_W-1:0]  row_len;

  always_comb begin
    w_ext = WCMP_W'(cfg_width_r);
    h_ext = HCMP_W'(cfg_height_r);
    b_ext = BCMP_W'(cfg_bpp_r);
    if (w_ext == '0) begin
      w_clamp = WCMP_W'(1);
    end else if (w_ext > WCMP_W'(MAX_WIDTH)) begin
      w_clamp = WCMP_W'(MAX_WIDTH);
    end else begin
      w_clamp = w_ext;
    end
    if (h_ext == '0) begin
      h_clamp = HCMP_W'(1);
    end else if (h_ext > HCMP_W'(MAX_HEIGHT)) begin
      h_clamp = HCMP_W'(MAX_HEIGHT);
    end else begin
      h_clamp = h_ext;
    end
    if (b_ext < BCMP_W'(MINB)) begin
      b_clamp = BCMP_W'(MINB);
    end else if (b_ext > BCMP_W'(MAX_BYTES_PER_PIXEL)) begin
      b_clamp = BCMP_W'(MAX_BYTES_PER_PIXEL);
    end else begin
      b_clamp = b_ext;
    end
    width   = w_clamp[WID_W-1:0];
    height  = h_clamp[HGT_W-1:0];
    bpp     = b_clamp[BPP_W-1:0];
    // full-width product: a maximum-width row does not fit in WID_W bits
    row_len = LEN_W'(width) * LEN_W'(bpp);
  end

  // ---------------------------------------------------------------- row state
  logic [COL_W-1:0]         col_r, col_nxt;
  logic [ROW_W-1:0]         row_r, row_nxt;
  pngunf_pkg::filt_t        filt_r, filt_nxt;
  logic                     bad_r, bad_nxt;
  logic                     first_r, first_nxt;
  logic                     await_r, await_nxt;
  // column mod m for every legal bytes-per-pixel value m, one lane each
  logic [KW-1:0]            kmod_r [MINB:MAX_BYTES_PER_PIXEL];
  logic                     kmod_clr;

  // reconstruct stage
  logic                     s1_v_r, s1_v_nxt;
  logic [7:0]               s1_byte_r;
  pngunf_pkg::filt_t        s1_filt_r;
  logic                     s1_bad_r;
  logic [KW-1:0]            s1_k_r;
  logic                     s1_a_ok_r;
  logic                     s1_b_ok_r;
  logic                     s1_eor_r;
  logic                     s1_eoi_r;
  logic [COL_W-1:0]         s1_idx_r;

  // left and upper-left neighbor bytes, one per byte of the pixel
  logic [7:0]               left_r   [MAX_BYTES_PER_PIXEL];
  logic [7:0]               upleft_r [MAX_BYTES_PER_PIXEL];

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic [7:0]               out_byte_r;
  logic                     out_bad_r;
  logic                     out_eor_r;
  logic                     out_eoi_r;

  logic                     out_load;
  logic                     s1_adv;
  logic                     in_xfer;
  logic                     in_data;
  logic                     await_eff;
  logic [KW-1:0]            k_cur;
  logic                     eor, eoi;
  logic [7:0]               ram_rdata;

  assign out_load = !out_valid_r || !out_stall;
  assign s1_adv   = s1_v_r && out_load;
  assign in_stall = s1_v_r && !out_load;
  assign in_xfer  = in_valid && !in_stall;
  assign await_eff = await_r || in_frame_start;
  assign in_data  = in_xfer && !await_eff;

  // pick the lane for the current bytes-per-pixel
  always_comb begin
    k_cur = '0;
    for (int m = MINB; m <= MAX_BYTES_PER_PIXEL; m++) begin
      if (bpp == BPP_W'(m)) begin
        k_cur = kmod_r[m];
      end
    end
  end

  assign eor = (LEN_W'(col_r) + LEN_W'(1)) >= row_len;
  assign eoi = eor && ((HGT_W'(row_r) + HGT_W'(1)) >= height);

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    filt_nxt  = filt_r;
    bad_nxt   = bad_r;
    first_nxt = first_r;
    await_nxt = await_r;
    kmod_clr  = 1'b0;
    if (in_xfer) begin
      if (await_eff) begin
        // filter-type byte
        if (in_byte > 8'(pngunf_pkg::FILT_PAETH)) begin
          filt_nxt = pngunf_pkg::FILT_NONE;
          bad_nxt  = 1'b1;
        end else begin
          filt_nxt = pngunf_pkg::filt_t'(in_byte[2:0]);
          bad_nxt  = 1'b0;
        end
        col_nxt   = '0;
        kmod_clr  = 1'b1;
        await_nxt = 1'b0;
        if (in_frame_start) begin
          row_nxt   = '0;
          first_nxt = 1'b1;
        end
      end else if (eor) begin
        col_nxt   = '0;
        kmod_clr  = 1'b1;
        await_nxt = 1'b1;
        if (eoi) begin
          row_nxt   = '0;
          first_nxt = 1'b1;
        end else begin
          row_nxt   = row_r + ROW_W'(1);
          first_nxt = 1'b0;
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------- line buffer
  // read at the input transfer, written when the byte leaves the stage
  logic [7:0] val;

  pngunf_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_prior_row (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_idx_r),
    .wdata (val),
    .re    (in_data),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- predictor
  logic [7:0]       nb_a, nb_b, nb_c, pred;
  logic [8:0]       sum_ab;
  logic signed [9:0] d_pa, d_pb, d_pc;
  logic [9:0]       pa, pb, pc;

  always_comb begin
    nb_a   = s1_a_ok_r ? left_r[s1_k_r] : 8'd0;
    nb_b   = s1_b_ok_r ? ram_rdata : 8'd0;
    nb_c   = (s1_a_ok_r && s1_b_ok_r) ? upleft_r[s1_k_r] : 8'd0;
    sum_ab = {1'b0, nb_a} + {1'b0, nb_b};
    // p = a + b - c: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
    d_pa = $signed({2'b00, nb_b}) - $signed({2'b00, nb_c});
    d_pb = $signed({2'b00, nb_a}) - $signed({2'b00, nb_c});
    d_pc = $signed({1'b0, sum_ab}) - $signed({1'b0, nb_c, 1'b0});
    pa   = d_pa[9] ? 10'(-d_pa) : 10'(d_pa);
    pb   = d_pb[9] ? 10'(-d_pb) : 10'(d_pb);
    pc   = d_pc[9] ? 10'(-d_pc) : 10'(d_pc);
    case (s1_filt_r)
      pngunf_pkg::FILT_SUB:   pred = nb_a;
      pngunf_pkg::FILT_UP:    pred = nb_b;
      pngunf_pkg::FILT_AVG:   pred = sum_ab[8:1];
      pngunf_pkg::FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = nb_a;
        end else if (pb <= pc) begin
          pred = nb_b;
        end else begin
          pred = nb_c;
        end
      end
      default:                pred = 8'd0;
    endcase
    val = s1_byte_r + pred;
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_data) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= CD_W'(1);
      cfg_height_r <= CD_W'(1);
      cfg_bpp_r    <= pngunf_pkg::CFG_BPP_W'(MINB);
      col_r        <= '0;
      row_r        <= '0;
      filt_r       <= pngunf_pkg::FILT_NONE;
      bad_r        <= 1'b0;
      first_r      <= 1'b1;
      await_r      <= 1'b1;
      s1_v_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int m = MINB; m <= MAX_BYTES_PER_PIXEL; m++) begin
        kmod_r[m] <= '0;
      end
      for (int i = 0; i < MAX_BYTES_PER_PIXEL; i++) begin
        left_r[i]   <= 8'd0;
        upleft_r[i] <= 8'd0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          pngunf_pkg::CFG_IMAGE_WIDTH:     cfg_width_r  <= cfg_data;
          pngunf_pkg::CFG_IMAGE_HEIGHT:    cfg_height_r <= cfg_data;
          pngunf_pkg::CFG_BYTES_PER_PIXEL: cfg_bpp_r    <= cfg_data[pngunf_pkg::CFG_BPP_W-1:0];
          default: ;
        endcase
      end
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      filt_r      <= filt_nxt;
      bad_r       <= bad_nxt;
      first_r     <= first_nxt;
      await_r     <= await_nxt;
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
      for (int m = MINB; m <= MAX_BYTES_PER_PIXEL; m++) begin
        if (kmod_clr) begin
          kmod_r[m] <= '0;
        end else if (in_data) begin
          kmod_r[m] <= (kmod_r[m] == KW'(m - 1)) ? '0 : kmod_r[m] + KW'(1);
        end
      end
      if (s1_adv) begin
        left_r[s1_k_r]   <= val;
        upleft_r[s1_k_r] <= nb_b;
      end
    end
    // payload
    if (in_data) begin
      s1_byte_r <= in_byte;
      s1_filt_r <= filt_r;
      s1_bad_r  <= bad_r;
      s1_k_r    <= k_cur;
      s1_a_ok_r <= LEN_W'(col_r) >= LEN_W'(bpp);
      s1_b_ok_r <= !first_r;
      s1_eor_r  <= eor;
      s1_eoi_r  <= eoi;
      s1_idx_r  <= col_r;
    end
    if (s1_adv) begin
      out_byte_r <= val;
      out_bad_r  <= s1_bad_r;
      out_eor_r  <= s1_eor_r;
      out_eoi_r  <= s1_eoi_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_bad_filter   = out_bad_r;
  assign out_end_of_row   = out_eor_r;
  assign out_end_of_image = out_eoi_r;

  // ---------------------------------------------------------------- checks
  a_stall_needs_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r)
    else $error("input stalled with empty reconstruct stage");

  a_data_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_data |=> s1_v_r)
    else $error("data transfer did not reach reconstruct stage");

  a_row_end_awaits_filter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_data && eor) |=> (await_r && col_r == '0))
    else $error("row end did not rearm filter byte");

  a_eoi_implies_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_eoi_r || out_eor_r))
    else $error("end of image without end of row");

endmodule

`default_nettype wire
